FILE: hdl/dual_bitmap_allocator_defines.svh
// Assertion helpers shared by the allocator RTL.
`ifndef DUAL_BITMAP_ALLOCATOR_DEFINES_SVH
`define DUAL_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DBA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/dba_pkg.sv
package dba_pkg;

    localparam int ITEM_W    = 14;
    localparam int VALUE_W   = 14;
    localparam int BLK_CNT_W = 14;
    localparam int INO_CNT_W = 11;
    localparam int BLK_SIZE_W = 14;
    localparam int INO_SIZE_W = 11;
    localparam int CFG_DATA_W = 14;

    localparam logic [BLK_CNT_W-1:0] BLK_CNT_MAX = '1;
    localparam logic [INO_CNT_W-1:0] INO_CNT_MAX = '1;

    // opcodes
    localparam logic [2:0] OP_MARK_USED = 3'd0;
    localparam logic [2:0] OP_MARK_FREE = 3'd1;
    localparam logic [2:0] OP_FIND      = 3'd2;
    localparam logic [2:0] OP_LOAD_BYTE = 3'd3;
    localparam logic [2:0] OP_SET_COUNT = 3'd4;

    // pool select
    localparam logic POOL_BLOCK = 1'b0;
    localparam logic POOL_INODE = 1'b1;

    // config register indexes
    localparam logic CFG_BLOCK_POOL_SIZE = 1'b0;
    localparam logic CFG_INODE_POOL_SIZE = 1'b1;

    typedef struct packed {
        logic [2:0]         opcode;
        logic               pool;
        logic [ITEM_W-1:0]  item_number;
        logic [VALUE_W-1:0] load_value;
    } t_req;

    typedef struct packed {
        logic [ITEM_W-1:0]    found_number;
        logic                 found;
        logic [BLK_CNT_W-1:0] free_count;
    } t_res;

    typedef struct packed {
        logic [2:0] bit_sel;
        logic       set;
        logic [2:0] start_bit;
    } t_bit_ctl;

    typedef struct packed {
        logic       hit;
        logic [2:0] bit_idx;
    } t_bit_res;

endpackage

FILE: hdl/dba_req_if.sv
interface dba_req_if;
    logic          valid;
    logic          ready;
    dba_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/dba_res_if.sv
interface dba_res_if;
    logic          valid;
    logic          ready;
    dba_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/dba_bit_unit.sv
// Shared byte unit: bit set/clear for marks, first-clear search for scans.
module dba_bit_unit (
    input  logic [7:0]        i_byte,
    input  dba_pkg::t_bit_ctl i_ctl,
    output logic [7:0]        o_byte,
    output dba_pkg::t_bit_res o_res
);

    logic [7:0] mask;

    always_comb begin
        mask = 8'd1 << i_ctl.bit_sel;
        if (i_ctl.set) begin
            o_byte = i_byte | mask;
        end else begin
            o_byte = i_byte & ~mask;
        end

        // lowest clear bit at or above the start bit
        o_res.hit     = 1'b0;
        o_res.bit_idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (!i_byte[i] && (3'(i) >= i_ctl.start_bit)) begin
                o_res.hit     = 1'b1;
                o_res.bit_idx = 3'(i);
            end
        end
    end

endmodule

FILE: hdl/dual_bitmap_allocator.sv
// Block and inode allocation bitmaps with saturating free counts.
//
// Requests arrive on i_req (valid/ready); each accepted transaction yields
// exactly one result transaction on o_res. Config (pool sizes) is written
// through i_cfg_we/i_cfg_idx/i_cfg_data; the user must write it only while
// the block is idle, a rule left unchecked by the block itself.
//
// Flow: an accepted request moves from idle to an execute state. Load byte,
// set count, unused opcodes and rejected marks go from there to the final
// state; mark used / mark free read the map byte in execute and write it
// back modified in a mark-write state. Find at zero count goes straight to
// the final state; else a scan takes one map byte per cycle through the
// shared bit unit until a hit or the end of the scan range.
// A new request is taken only with the sequencer back in idle.
//
// Reset: with i_req.ready low, a clearing pass zeroes both maps, one byte
// per cycle over max(BLOCK_BITS, INODE_BITS)/8 addresses (1024 at default).
// Counts reset to zero, pool sizes to 8192/1024. Output stall: the result
// register holds until o_res.ready; a finished operation waits in its final
// state, and one more request can be accepted while a result is pending.
module dual_bitmap_allocator #(
    parameter int BLOCK_BITS       = 8192,
    parameter int INODE_BITS       = 1024,
    parameter int FIRST_USER_INODE = 11
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    dba_req_if.sink                          i_req,
    dba_res_if.source                        o_res,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [dba_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

`include "dual_bitmap_allocator_defines.svh"

    localparam int BLK_DEPTH = BLOCK_BITS / 8;
    localparam int INO_DEPTH = INODE_BITS / 8;
    localparam int MAX_DEPTH = (BLK_DEPTH > INO_DEPTH) ? BLK_DEPTH : INO_DEPTH;
    localparam int BAW = (BLK_DEPTH > 1) ? $clog2(BLK_DEPTH) : 1;
    localparam int IAW = (INO_DEPTH > 1) ? $clog2(INO_DEPTH) : 1;
    localparam int SW  = $clog2(MAX_DEPTH + 1);
    localparam int INO_START_BYTE = (FIRST_USER_INODE - 1) / 8;
    localparam int INO_START_BIT  = (FIRST_USER_INODE - 1) % 8;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_MARK_WR,
        ST_SCAN,
        ST_FIN
    } t_state;

    t_state r_state;

    // config and counts
    logic [dba_pkg::BLK_SIZE_W-1:0] r_blk_size;
    logic [dba_pkg::INO_SIZE_W-1:0] r_ino_size;
    logic [dba_pkg::BLK_CNT_W-1:0]  r_free_blk;
    logic [dba_pkg::INO_CNT_W-1:0]  r_free_ino;

    dba_pkg::t_req r_req;
    logic [SW-1:0] r_clr;
    logic [SW-1:0] r_iss;
    logic [SW-1:0] r_chk;
    logic [SW-1:0] r_limit;
    logic          r_pend;

    logic [dba_pkg::ITEM_W-1:0] r_res_num;
    logic                       r_res_found;
    dba_pkg::t_res              r_out;
    logic                       r_out_vld;

    // bitmap memories
    logic [7:0] blk_mem [BLK_DEPTH];
    logic [7:0] ino_mem [INO_DEPTH];
    logic [7:0] r_blk_q;
    logic [7:0] r_ino_q;

    logic                        is_ino;
    logic [dba_pkg::ITEM_W-1:0]  im1;
    logic                        mark_ok;
    logic                        load_ok;
    logic [SW-1:0]               mark_byte;
    logic [SW-1:0]               rd_addr;
    logic                        blk_we;
    logic                        ino_we;
    logic [SW-1:0]               wr_addr;
    logic [7:0]                  wr_data;
    logic [SW-1:0]               start_byte;
    logic [dba_pkg::ITEM_W-1:0]  start_item;
    logic [SW-1:0]               find_limit;
    logic                        cnt_zero;
    logic                        slot_free;
    logic [dba_pkg::BLK_CNT_W-1:0] cur_count;

    dba_pkg::t_bit_ctl bit_ctl;
    dba_pkg::t_bit_res bit_res;
    logic [7:0]        bit_byte;

    dba_bit_unit u_bit (
        .i_byte (is_ino ? r_ino_q : r_blk_q),
        .i_ctl  (bit_ctl),
        .o_byte (bit_byte),
        .o_res  (bit_res)
    );

    always_comb begin
        is_ino    = (r_req.pool == dba_pkg::POOL_INODE);
        im1       = r_req.item_number - dba_pkg::ITEM_W'(1);
        mark_byte = SW'(im1 >> 3);
        mark_ok   = (r_req.item_number != '0)
                    && (32'(r_req.item_number) <= (is_ino ? INODE_BITS : BLOCK_BITS))
                    && (32'(im1 >> 3) < (is_ino ? INO_DEPTH : BLK_DEPTH));
        load_ok   = 32'(r_req.item_number) < (is_ino ? INO_DEPTH : BLK_DEPTH);

        start_byte = is_ino ? SW'(INO_START_BYTE) : '0;
        start_item = is_ino ? dba_pkg::ITEM_W'(FIRST_USER_INODE) : dba_pkg::ITEM_W'(1);
        if (is_ino) begin
            find_limit = (32'(r_ino_size >> 3) < INO_DEPTH) ? SW'(r_ino_size >> 3)
                                                            : SW'(INO_DEPTH);
        end else begin
            find_limit = (32'(r_blk_size >> 3) < BLK_DEPTH) ? SW'(r_blk_size >> 3)
                                                            : SW'(BLK_DEPTH);
        end
        cur_count = is_ino ? dba_pkg::BLK_CNT_W'(r_free_ino) : r_free_blk;
        cnt_zero  = (cur_count == '0);
        slot_free = !r_out_vld || o_res.ready;

        // one unit: modify for marks, search for scans
        bit_ctl.bit_sel   = im1[2:0];
        bit_ctl.set       = (r_req.opcode == dba_pkg::OP_MARK_USED);
        bit_ctl.start_bit = (is_ino && (r_chk == start_byte)) ? 3'(INO_START_BIT) : 3'd0;

        rd_addr = (r_state == ST_SCAN) ? r_iss : mark_byte;

        blk_we  = 1'b0;
        ino_we  = 1'b0;
        wr_addr = r_clr;
        wr_data = 8'd0;
        unique case (r_state)
            ST_CLEAR: begin
                blk_we = (32'(r_clr) < BLK_DEPTH);
                ino_we = (32'(r_clr) < INO_DEPTH);
            end
            ST_EXEC: begin
                if (r_req.opcode == dba_pkg::OP_LOAD_BYTE && load_ok) begin
                    blk_we  = !is_ino;
                    ino_we  = is_ino;
                    wr_addr = SW'(r_req.item_number);
                    wr_data = r_req.load_value[7:0];
                end
            end
            ST_MARK_WR: begin
                blk_we  = !is_ino;
                ino_we  = is_ino;
                wr_addr = mark_byte;
                wr_data = bit_byte;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (blk_we) begin
            blk_mem[BAW'(wr_addr)] <= wr_data;
        end
        r_blk_q <= blk_mem[BAW'(rd_addr)];
    end

    always_ff @(posedge i_clk) begin
        if (ino_we) begin
            ino_mem[IAW'(wr_addr)] <= wr_data;
        end
        r_ino_q <= ino_mem[IAW'(rd_addr)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr      <= '0;
            r_pend     <= 1'b0;
            r_out_vld  <= 1'b0;
            r_free_blk <= '0;
            r_free_ino <= '0;
            r_blk_size <= dba_pkg::BLK_SIZE_W'(8192);
            r_ino_size <= dba_pkg::INO_SIZE_W'(1024);
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == dba_pkg::CFG_BLOCK_POOL_SIZE) begin
                    r_blk_size <= i_cfg_data;
                end else begin
                    r_ino_size <= i_cfg_data[dba_pkg::INO_SIZE_W-1:0];
                end
            end

            // in the final state the slot is reloaded instead
            if (o_res.ready && r_state != ST_FIN) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + SW'(1);
                    if (r_clr == SW'(MAX_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_req   <= i_req.data;
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_res_num   <= '0;
                    r_res_found <= 1'b0;
                    r_state     <= ST_FIN;
                    case (r_req.opcode) inside
                        dba_pkg::OP_MARK_USED, dba_pkg::OP_MARK_FREE: begin
                            // map byte read issued this cycle
                            if (mark_ok) begin
                                r_state <= ST_MARK_WR;
                            end
                        end
                        dba_pkg::OP_FIND: begin
                            if (!cnt_zero) begin
                                r_iss   <= start_byte;
                                r_limit <= find_limit;
                                r_pend  <= 1'b0;
                                r_state <= ST_SCAN;
                            end
                        end
                        dba_pkg::OP_SET_COUNT: begin
                            if (is_ino) begin
                                r_free_ino <= (r_req.load_value
                                               > dba_pkg::VALUE_W'(dba_pkg::INO_CNT_MAX))
                                              ? dba_pkg::INO_CNT_MAX
                                              : r_req.load_value[dba_pkg::INO_CNT_W-1:0];
                            end else begin
                                r_free_blk <= r_req.load_value;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                ST_MARK_WR: begin
                    if (r_req.opcode == dba_pkg::OP_MARK_USED) begin
                        if (is_ino) begin
                            if (r_free_ino != '0) r_free_ino <= r_free_ino - 1'b1;
                        end else begin
                            if (r_free_blk != '0) r_free_blk <= r_free_blk - 1'b1;
                        end
                    end else begin
                        if (is_ino) begin
                            if (r_free_ino != dba_pkg::INO_CNT_MAX) begin
                                r_free_ino <= r_free_ino + 1'b1;
                            end
                        end else begin
                            if (r_free_blk != dba_pkg::BLK_CNT_MAX) begin
                                r_free_blk <= r_free_blk + 1'b1;
                            end
                        end
                    end
                    r_state <= ST_FIN;
                end
                ST_SCAN: begin
                    if (r_pend && bit_res.hit) begin
                        r_res_num   <= dba_pkg::ITEM_W'({1'b0, r_chk, bit_res.bit_idx}
                                                        + (SW + 4)'(1));
                        r_res_found <= 1'b1;
                        r_state     <= ST_FIN;
                    end else if (r_iss < r_limit) begin
                        // read of r_iss goes out now, checked next cycle
                        r_chk  <= r_iss;
                        r_pend <= 1'b1;
                        r_iss  <= r_iss + SW'(1);
                    end else if (r_pend) begin
                        r_pend <= 1'b0;
                    end else begin
                        r_res_found <= 1'b0;
                        r_res_num   <= (r_limit > start_byte)
                                       ? dba_pkg::ITEM_W'({r_limit, 3'b001})
                                       : start_item;
                        r_state     <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (slot_free) begin
                        r_out.found_number <= r_res_num;
                        r_out.found        <= r_res_found;
                        r_out.free_count   <= cur_count;
                        r_out_vld          <= 1'b1;
                        r_state            <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

    `DBA_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, i_req.valid && i_req.ready,
        r_state == ST_EXEC, "accepted transaction not dispatched")
    `DBA_ASSERT_SAME(a_scan_in_range, i_clk, i_rst_n, r_state == ST_SCAN && r_pend,
        r_chk < r_limit, "scan checks a byte beyond its limit")
    `DBA_ASSERT_SAME(a_found_nonzero, i_clk, i_rst_n, r_state == ST_FIN && r_res_found,
        r_res_num != '0, "found result with item number zero")
    `DBA_ASSERT_NEXT(a_out_from_fin, i_clk, i_rst_n, r_state != ST_FIN && !r_out_vld,
        !r_out_vld, "result raised outside final state")

endmodule

FILE: verif/alloc_check_pkg.sv
`timescale 1ns / 100ps

package alloc_check_pkg;

    // RTL defaults
    localparam int unsigned BLOCK_BITS       = 8192;
    localparam int unsigned INODE_BITS       = 1024;
    localparam int unsigned FIRST_USER_INODE = 11;
    localparam int unsigned BLOCK_BYTES      = BLOCK_BITS / 8;
    localparam int unsigned INODE_BYTES      = INODE_BITS / 8;

    class alloc_scoreboard;
        // row 0: block map, row 1: inode map (first INODE_BYTES entries only)
        logic [7:0]    bitmap [2][BLOCK_BYTES];
        int unsigned   free_cnt [2];
        int unsigned   pool_size [2];
        int unsigned   last_found [2];
        dba_pkg::t_res pending_results [$];
        int            errors;

        function new();
            foreach (bitmap[p, i]) bitmap[p][i] = 8'h00;
            free_cnt   = '{0, 0};
            pool_size  = '{BLOCK_BITS, INODE_BITS};
            last_found = '{0, 0};
            errors     = 0;
        endfunction

        function void configure(int unsigned blk, int unsigned ino);
            pool_size[dba_pkg::POOL_BLOCK] = int'(dba_pkg::BLK_SIZE_W'(blk));
            pool_size[dba_pkg::POOL_INODE] = int'(dba_pkg::INO_SIZE_W'(ino));
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // Applies one request to the mirrored maps and counts.
        function dba_pkg::t_res apply_request(dba_pkg::t_req r);
            dba_pkg::t_res res;
            int unsigned   p, item, depth, cmax, limit, idx, bitpos;
            logic [7:0]    mask;
            res   = '0;
            p     = (r.pool == dba_pkg::POOL_INODE) ? 1 : 0;
            item  = r.item_number;
            depth = p ? INODE_BYTES : BLOCK_BYTES;
            cmax  = p ? int'(dba_pkg::INO_CNT_MAX) : int'(dba_pkg::BLK_CNT_MAX);
            case (r.opcode) inside
                dba_pkg::OP_MARK_USED, dba_pkg::OP_MARK_FREE: begin
                    // item 0 or past the map: no effect at all
                    if (item != 0 && item <= depth * 8) begin
                        idx  = (item - 1) / 8;
                        mask = 8'h01 << ((item - 1) % 8);
                        if (r.opcode == dba_pkg::OP_MARK_USED) begin
                            bitmap[p][idx] |= mask;
                            if (free_cnt[p] > 0) free_cnt[p]--;
                        end else begin
                            bitmap[p][idx] &= ~mask;
                            if (free_cnt[p] < cmax) free_cnt[p]++;
                        end
                    end
                end
                dba_pkg::OP_FIND: begin
                    if (free_cnt[p] != 0) begin
                        limit = pool_size[p] / 8;
                        if (limit > depth) limit = depth;
                        idx    = p ? (FIRST_USER_INODE - 1) / 8 : 0;
                        bitpos = p ? (FIRST_USER_INODE - 1) % 8 : 0;
                        while (idx < limit && bitmap[p][idx][bitpos]) begin
                            bitpos++;
                            if (bitpos == 8) begin
                                bitpos = 0;
                                idx++;
                            end
                        end
                        res.found        = (idx < limit);
                        res.found_number = dba_pkg::ITEM_W'(idx * 8 + bitpos + 1);
                    end
                    last_found[p] = res.found ? int'(res.found_number) : 0;
                end
                dba_pkg::OP_LOAD_BYTE: begin
                    if (item < depth) bitmap[p][item] = r.load_value[7:0];
                end
                dba_pkg::OP_SET_COUNT: begin
                    free_cnt[p] = (r.load_value > cmax) ? cmax : int'(r.load_value);
                end
                default: ;
            endcase
            res.free_count = dba_pkg::BLK_CNT_W'(free_cnt[p]);
            return res;
        endfunction

        function void note_request(dba_pkg::t_req r);
            pending_results.push_back(apply_request(r));
        endfunction

        function void check_result(dba_pkg::t_res got);
            dba_pkg::t_res want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: found_number %0d found %0d free_count %0d",
                       got.found_number, got.found, got.free_count);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.found_number !== want.found_number) begin
                $error("found_number: expected %0d, actual %0d",
                       want.found_number, got.found_number);
                errors++;
            end
            if (got.found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                errors++;
            end
            if (got.free_count !== want.free_count) begin
                $error("free_count: expected %0d, actual %0d",
                       want.free_count, got.free_count);
                errors++;
            end
        endfunction
    endclass

endpackage

FILE: verif/dual_bitmap_allocator_test.sv
`timescale 1ns / 100ps

module dual_bitmap_allocator_test;

    // opcodes the block leaves unassigned
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    localparam int ITEMS_PER_PHASE = 270;
    localparam int NUM_PHASES      = 8;
    localparam int SETTLE_CYCLES   = 8;

    localparam int unsigned BLOCK_BITS       = alloc_check_pkg::BLOCK_BITS;
    localparam int unsigned INODE_BITS       = alloc_check_pkg::INODE_BITS;
    localparam int unsigned FIRST_USER_INODE = alloc_check_pkg::FIRST_USER_INODE;
    localparam int unsigned BLOCK_BYTES      = alloc_check_pkg::BLOCK_BYTES;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic                           cfg_idx;
    logic [dba_pkg::CFG_DATA_W-1:0] cfg_data;

    dba_req_if req_if();
    dba_res_if res_if();

    alloc_check_pkg::alloc_scoreboard tracker;

    // gap bookkeeping for both sides of the block
    int req_gap;
    int req_streak;
    int res_streak;
    bit hold_off;

    // pool sizes per random phase; extremes included (0, nominal, field max)
    int unsigned blk_sizes [NUM_PHASES] = '{8192, 64, 0, 16383, 8, 200, 1000, 8192};
    int unsigned ino_sizes [NUM_PHASES] = '{1024, 88, 0, 2047, 16, 300, 120, 1024};

    dual_bitmap_allocator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Idle cycles before the next transaction: mostly drawn at random, with
    // occasional back-to-back stretches so every phase of the sequencer sees both.
    function automatic int draw_gap(ref int streak);
        if (streak > 0) begin
            streak--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            streak = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    function automatic dba_pkg::t_req make_req(logic [2:0] op, logic pool,
                                               int unsigned item, int unsigned val);
        dba_pkg::t_req r;
        r.opcode      = op;
        r.pool        = pool;
        r.item_number = dba_pkg::ITEM_W'(item);
        r.load_value  = dba_pkg::VALUE_W'(val);
        return r;
    endfunction

    // Random request, biased toward allocator-like traffic: search, claim the
    // hit, release something, plus preloads and a little noise.
    function automatic dba_pkg::t_req random_request();
        dba_pkg::t_req r;
        int unsigned   pick, cap, span;
        pick          = $urandom_range(0, 99);
        r.pool        = 1'($urandom_range(0, 1));
        r.item_number = dba_pkg::ITEM_W'($urandom());
        r.load_value  = dba_pkg::VALUE_W'($urandom());
        r.opcode      = dba_pkg::OP_FIND;
        cap  = (r.pool == dba_pkg::POOL_INODE) ? INODE_BITS : BLOCK_BITS;
        span = tracker.pool_size[r.pool];
        if (span > cap) span = cap;
        if (span == 0) span = 8;
        if (pick < 30) begin
            r.opcode = dba_pkg::OP_FIND;
        end else if (pick < 55) begin
            // claim what the last search handed out
            r.opcode = dba_pkg::OP_MARK_USED;
            if (tracker.last_found[r.pool] != 0 && $urandom_range(0, 3) != 0)
                r.item_number = dba_pkg::ITEM_W'(tracker.last_found[r.pool]);
            else
                r.item_number = dba_pkg::ITEM_W'($urandom_range(1, span));
        end else if (pick < 75) begin
            r.opcode      = dba_pkg::OP_MARK_FREE;
            r.item_number = dba_pkg::ITEM_W'($urandom_range(1, span));
        end else if (pick < 84) begin
            // mostly in-range addresses; full bytes help reach no-hit scans
            r.opcode = dba_pkg::OP_LOAD_BYTE;
            if ($urandom_range(0, 7) != 0)
                r.item_number = dba_pkg::ITEM_W'($urandom_range(0, (span - 1) / 8));
            if ($urandom_range(0, 2) == 0) r.load_value[7:0] = 8'hFF;
        end else if (pick < 92) begin
            r.opcode = dba_pkg::OP_SET_COUNT;
            case ($urandom_range(0, 7))
                0:       r.load_value = '0;
                1:       r.load_value = '1;
                default: r.load_value = dba_pkg::VALUE_W'($urandom_range(1, span));
            endcase
        end else if ($urandom_range(0, 1) == 0) begin
            r.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end else begin
            // marks the block must drop: item zero or past the map
            r.opcode      = $urandom_range(0, 1) ? dba_pkg::OP_MARK_USED
                                                 : dba_pkg::OP_MARK_FREE;
            r.item_number = $urandom_range(0, 1) ? '0
                          : dba_pkg::ITEM_W'($urandom_range(cap + 1,
                                                            (1 << dba_pkg::ITEM_W) - 1));
        end
        return r;
    endfunction

    // Offer one request and hold it until accepted. valid is only lowered
    // when the next gap is nonzero, so back-to-back requests never see a
    // low/high pair in the same step.
    task automatic send_request(input dba_pkg::t_req r);
        repeat (req_gap) @(posedge i_clk);
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        tracker.note_request(r);
        req_gap = draw_gap(req_streak);
        if (req_gap != 0) req_if.valid <= 1'b0;
    endtask

    task automatic stop_requests();
        if (req_gap == 0) req_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Both size registers, back to back; only called with the block idle.
    task automatic write_pool_sizes(input int unsigned blk, input int unsigned ino);
        cfg_we   <= 1'b1;
        cfg_idx  <= dba_pkg::CFG_BLOCK_POOL_SIZE;
        cfg_data <= dba_pkg::CFG_DATA_W'(blk);
        @(posedge i_clk);
        cfg_idx  <= dba_pkg::CFG_INODE_POOL_SIZE;
        cfg_data <= dba_pkg::CFG_DATA_W'(ino);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        tracker.configure(blk, ino);
    endtask

    // Result side: random stalls, plus a long hold-off on request so the
    // pending result blocks the sequencer and i_req.ready drops.
    initial begin : result_sink
        int stall;
        res_if.ready = 1'b0;
        forever begin
            stall = draw_gap(res_streak);
            if (hold_off) begin
                stall    = 400;
                hold_off = 1'b0;
            end
            if (stall != 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
            tracker.check_result(res_if.data);
        end
    end

    initial begin : stimulus
        tracker      = new();
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = dba_pkg::CFG_BLOCK_POOL_SIZE;
        cfg_data     = '0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        req_gap      = 0;
        req_streak   = 0;
        res_streak   = 0;
        hold_off     = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the map-clearing pass after reset is covered by waiting on ready

        // ---- directed: reset pool sizes ----
        // count zero
        send_request(make_req(dba_pkg::OP_FIND, dba_pkg::POOL_BLOCK, 1, 0));
        // count at max
        send_request(make_req(dba_pkg::OP_SET_COUNT, dba_pkg::POOL_BLOCK, 0, 14'h3FFF));
        // saturates high
        send_request(make_req(dba_pkg::OP_MARK_FREE, dba_pkg::POOL_BLOCK, 1, 0));
        // last block
        send_request(make_req(dba_pkg::OP_MARK_USED, dba_pkg::POOL_BLOCK, BLOCK_BITS, 0));
        // past map
        send_request(make_req(dba_pkg::OP_MARK_USED, dba_pkg::POOL_BLOCK,
                              BLOCK_BITS + 1, 0));
        // item zero
        send_request(make_req(dba_pkg::OP_MARK_USED, dba_pkg::POOL_BLOCK, 0, 0));
        send_request(make_req(dba_pkg::OP_FIND, dba_pkg::POOL_BLOCK, 0, 0));
        // upper bits dropped
        send_request(make_req(dba_pkg::OP_LOAD_BYTE, dba_pkg::POOL_BLOCK, 0, 14'h3FFF));
        // bad addr
        send_request(make_req(dba_pkg::OP_LOAD_BYTE, dba_pkg::POOL_BLOCK,
                              BLOCK_BYTES, 14'h00FF));
        // skips first byte
        send_request(make_req(dba_pkg::OP_FIND, dba_pkg::POOL_BLOCK, 0, 0));
        // clamps to 2047
        send_request(make_req(dba_pkg::OP_SET_COUNT, dba_pkg::POOL_INODE, 0, 14'h3FFF));
        // saturates high
        send_request(make_req(dba_pkg::OP_MARK_FREE, dba_pkg::POOL_INODE, INODE_BITS, 0));
        // past map
        send_request(make_req(dba_pkg::OP_MARK_USED, dba_pkg::POOL_INODE,
                              INODE_BITS + 1, 0));
        // first user inode
        send_request(make_req(dba_pkg::OP_FIND, dba_pkg::POOL_INODE, 0, 0));
        send_request(make_req(dba_pkg::OP_SET_COUNT, dba_pkg::POOL_INODE, 0, 0));
        // stays 0
        send_request(make_req(dba_pkg::OP_MARK_USED, dba_pkg::POOL_INODE,
                              FIRST_USER_INODE, 0));
        send_request(make_req(OP_UNUSED_LO, dba_pkg::POOL_BLOCK, 3, 14'h1234));
        send_request(make_req(OP_UNUSED_HI, dba_pkg::POOL_INODE, 5, 14'h2BCD));
        stop_requests();
        wait_drained();

        // ---- directed: tiny pools, scans with nothing clear ----
        write_pool_sizes(16, 15);
        send_request(make_req(dba_pkg::OP_LOAD_BYTE, dba_pkg::POOL_BLOCK, 1, 14'h00FF));
        // full range used
        send_request(make_req(dba_pkg::OP_FIND, dba_pkg::POOL_BLOCK, 0, 0));
        send_request(make_req(dba_pkg::OP_SET_COUNT, dba_pkg::POOL_INODE, 0, 5));
        // scan never starts
        send_request(make_req(dba_pkg::OP_FIND, dba_pkg::POOL_INODE, 0, 0));
        stop_requests();
        wait_drained();
        write_pool_sizes(0, 15);
        // empty block pool
        send_request(make_req(dba_pkg::OP_FIND, dba_pkg::POOL_BLOCK, 0, 0));
        stop_requests();
        wait_drained();

        // ---- random phases, one pool-size setting each ----
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_pool_sizes(blk_sizes[p], ino_sizes[p]);
            if (p == 1 || p == 5) hold_off = 1'b1;
            repeat (ITEMS_PER_PHASE) send_request(random_request());
            stop_requests();
            wait_drained();
        end

        // let any stray result show up before the verdict
        repeat (50) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: several times the slowest legal run
    // (every request a full 1024-byte scan plus worst-case stalls).
    initial begin : watchdog
        #(64'd20_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
